// ----- src/swpsc_pkg.sv -----
// ============================================================================
// swpsc_pkg
// Shared widths, defaults and payload types of the sliding window pair-sum
// checker.
// ============================================================================
`default_nettype none

package swpsc_pkg;

    localparam int VALUE_W     = 31;
    localparam int WINDOW_DEF  = 25;
    localparam int WINDOW_MIN  = 2;
    localparam int WINDOW_MAX  = 64;

    typedef logic [VALUE_W-1:0] value_t;

    // one input request as held inside the block
    typedef struct packed {
        value_t value;
        logic   start_req;
    } item_t;

    // one result as handed from the sequencer to the output register
    typedef struct packed {
        logic   checked;
        logic   pair_found;
        value_t echo_value;
    } res_t;

endpackage

`default_nettype wire

// ----- src/swpsc_in_if.sv -----
// ============================================================================
// swpsc_in_if
// Input channel: valid/ready handshake carrying one stream number and its
// start mark.
// ============================================================================
`default_nettype none

interface swpsc_in_if;

    logic                         valid;
    logic                         ready;
    logic [swpsc_pkg::VALUE_W-1:0] value;
    logic                         start_req;

    modport source (output valid, output value, output start_req, input ready);
    modport sink   (input valid, input value, input start_req, output ready);

endinterface

`default_nettype wire

// ----- src/swpsc_out_if.sv -----
// ============================================================================
// swpsc_out_if
// Result channel: valid/ready handshake carrying the check flags and the
// number that was checked.
// ============================================================================
`default_nettype none

interface swpsc_out_if;

    logic                         valid;
    logic                         ready;
    logic                         checked;
    logic                         pair_found;
    logic [swpsc_pkg::VALUE_W-1:0] echo_value;

    modport source (output valid, output checked, output pair_found, output echo_value,
                    input ready);
    modport sink   (input valid, input checked, input pair_found, input echo_value,
                    output ready);

endinterface

`default_nettype wire

// ----- src/sliding_window_pair_sum_check_top.sv -----
// ============================================================================
// sliding_window_pair_sum_check_top
// Keeps the last WINDOW numbers of a stream and flags each new number that
// equals the sum of two window entries at distinct positions.
// ============================================================================
// Usage:
//   in_ch  : one request per number (value, start_req). start_req restarts
//            the window fill with this number as its first entry.
//   out_ch : exactly one result per request, in order: checked (window was
//            full), pair_found, echo_value.
//   Flow: a number taken while the window fills goes from the dispatch
//   state straight to the result. Once the window is full, every slot pair
//   is read from the window store over its two read ports, one pair per
//   cycle, stopping at the first match, and the oldest entry is then
//   replaced. The pair sweep sets the rate.
//   The input is taken again as soon as the result has moved to the output
//   register; a stalled receiver holds that register and, behind it, at
//   most one finished result inside the sequencer.
//   Reset: rst_n (async, active low) empties the window; store contents
//   are not cleared and are never used before being written.
// ============================================================================
`default_nettype none

module sliding_window_pair_sum_check_top #(
    parameter int WINDOW = swpsc_pkg::WINDOW_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    swpsc_in_if.sink     in_ch,
    swpsc_out_if.source  out_ch
);

    localparam int AW = $clog2(WINDOW);

    swpsc_pkg::item_t              item;
    swpsc_pkg::res_t               res;
    swpsc_pkg::res_t               out_res_reg;
    logic                          out_valid_reg;
    logic                          in_ready;
    logic                          in_take;
    logic                          res_valid;
    logic                          res_take;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [swpsc_pkg::VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]                 mem_raddr_a;
    logic [AW-1:0]                 mem_raddr_b;
    logic [swpsc_pkg::VALUE_W-1:0] mem_rdata_a;
    logic [swpsc_pkg::VALUE_W-1:0] mem_rdata_b;

    assign item.value     = in_ch.value;
    assign item.start_req = in_ch.start_req;
    assign in_ch.ready    = in_ready;
    assign in_take        = in_ch.valid && in_ready;

    assign res_take = res_valid && (!out_valid_reg || out_ch.ready);

    swpsc_ctrl #(
        .WINDOW (WINDOW),
        .AW     (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ready    (in_ready),
        .in_take     (in_take),
        .item        (item),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    swpsc_win_ram #(
        .WINDOW (WINDOW),
        .AW     (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.checked    = out_res_reg.checked;
    assign out_ch.pair_found = out_res_reg.pair_found;
    assign out_ch.echo_value = out_res_reg.echo_value;

    // a match can only come from a full-window check
    a_found_implies_checked: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.checked || !res.pair_found)
    ) else $error("pair_found without a full-window check");

    // the store is written only while a request is being worked on
    a_write_only_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_we |-> !in_ready
    ) else $error("window store written while idle");

    // a request taken makes the block busy in the next cycle
    a_take_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_take |=> !in_ch.ready
    ) else $error("input ready right after a request was taken");

endmodule

`default_nettype wire

// ----- src/swpsc_win_ram.sv -----
// ============================================================================
// swpsc_win_ram
// Window store: one write port and two read ports, read data registered.
// ============================================================================
`default_nettype none

module swpsc_win_ram #(
    parameter int WINDOW = swpsc_pkg::WINDOW_DEF,
    parameter int AW     = $clog2(WINDOW)
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [swpsc_pkg::VALUE_W-1:0] wdata,
    input  wire logic [AW-1:0]                 raddr_a,
    input  wire logic [AW-1:0]                 raddr_b,
    output logic      [swpsc_pkg::VALUE_W-1:0] rdata_a,
    output logic      [swpsc_pkg::VALUE_W-1:0] rdata_b
);

    logic [swpsc_pkg::VALUE_W-1:0] mem [WINDOW];
    logic [swpsc_pkg::VALUE_W-1:0] rdata_a_reg;
    logic [swpsc_pkg::VALUE_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ----- src/swpsc_ctrl.sv -----
// ============================================================================
// swpsc_ctrl
// Sequencer: stores filling numbers, sweeps all slot pairs through the window
// store for full-window checks until a match, then replaces the oldest entry.
// ============================================================================
`default_nettype none

module swpsc_ctrl #(
    parameter int WINDOW = swpsc_pkg::WINDOW_DEF,
    parameter int AW     = $clog2(WINDOW)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input side
    output logic                               in_ready,
    input  wire logic                          in_take,
    input  wire swpsc_pkg::item_t              item,
    // result side
    output logic                               res_valid,
    output swpsc_pkg::res_t                    res,
    input  wire logic                          res_take,
    // window store
    output logic                               mem_we,
    output logic      [AW-1:0]                 mem_waddr,
    output logic      [swpsc_pkg::VALUE_W-1:0] mem_wdata,
    output logic      [AW-1:0]                 mem_raddr_a,
    output logic      [AW-1:0]                 mem_raddr_b,
    input  wire logic [swpsc_pkg::VALUE_W-1:0] mem_rdata_a,
    input  wire logic [swpsc_pkg::VALUE_W-1:0] mem_rdata_b
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] FULL    = CW'(WINDOW);
    localparam logic [AW-1:0] LAST_B  = AW'(WINDOW - 1);
    localparam logic [AW-1:0] LAST_A  = AW'(WINDOW - 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DISP   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]             state_reg,  state_next;
    swpsc_pkg::item_t       item_reg,   item_next;
    logic [CW-1:0]          fill_reg,   fill_next;
    logic [AW-1:0]          oldest_reg, oldest_next;
    logic [AW-1:0]          a_reg,      a_next;
    logic [AW-1:0]          b_reg,      b_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   found_reg,  found_next;
    logic                   chk_reg,    chk_next;

    logic [CW-1:0]          fill_eff;
    logic [swpsc_pkg::VALUE_W:0] pair_sum;
    logic                   hit;

    // pair sum one bit wider so it cannot wrap
    assign pair_sum = {1'b0, mem_rdata_a} + {1'b0, mem_rdata_b};
    assign hit      = rd_vld_reg && (pair_sum == {1'b0, item_reg.value});
    assign fill_eff = item_reg.start_req ? '0 : fill_reg;

    assign mem_raddr_a = a_reg;
    assign mem_raddr_b = b_reg;
    assign mem_wdata   = item_reg.value;

    assign in_ready       = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_RESULT);
    assign res.checked    = chk_reg;
    assign res.pair_found = found_reg;
    assign res.echo_value = item_reg.value;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        rd_vld_next = 1'b0;
        found_next  = found_reg;
        chk_next    = chk_reg;
        mem_we      = 1'b0;
        mem_waddr   = oldest_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    item_next  = item;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                found_next = 1'b0;
                if (item_reg.start_req)
                begin
                    oldest_next = '0;
                end
                if (fill_eff < FULL)
                begin
                    // while filling, oldest slot is zero, so next free slot = fill
                    mem_we     = 1'b1;
                    mem_waddr  = fill_eff[AW-1:0];
                    fill_next  = fill_eff + CW'(1);
                    chk_next   = 1'b0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    a_next     = '0;
                    b_next     = AW'(1);
                    chk_next   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_vld_next = 1'b1;
                if (hit)
                begin
                    found_next  = 1'b1;
                    rd_vld_next = 1'b0;
                    state_next  = ST_WRITE;
                end
                else if (a_reg == LAST_A)
                begin
                    state_next = ST_DRAIN;
                end
                else if (b_reg == LAST_B)
                begin
                    a_next = a_reg + AW'(1);
                    b_next = a_reg + AW'(2);
                end
                else
                begin
                    b_next = b_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                end
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we      = 1'b1;
                mem_waddr   = oldest_reg;
                oldest_next = (oldest_reg == LAST_B) ? '0 : oldest_reg + AW'(1);
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            oldest_reg <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            chk_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
            chk_reg    <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
    end

endmodule

`default_nettype wire
